[rtl/htx_pkg.sv]
`default_nettype none
package htx_pkg;

  // channel and register widths
  localparam int ChanW   = 16;
  localparam int GainW   = 16;
  localparam int ByteW   = 8;
  localparam int MantW   = 11;                  // hidden bit plus 10 mantissa bits
  localparam int ProdW   = MantW + GainW;       // mantissa times gain
  localparam int ScaledW = ProdW + 8;           // times 255
  localparam int ShiftW  = 6;                   // shift 7..36
  localparam int NumLanes = 3;

  // register indexes
  localparam logic CfgSourceFormat = 1'b0;
  localparam logic CfgExposureGain = 1'b1;

  // source formats
  localparam logic FormatHalf = 1'b0;
  localparam logic FormatByte = 1'b1;

  // binary16 decode constants
  localparam logic [4:0]        HalfExpMax    = 5'h1f;
  localparam logic [MantW-1:0]  HalfHidden    = 11'd1024;
  localparam logic [MantW-1:0]  HalfInfMant   = 11'd2047;
  localparam logic [ShiftW-1:0] HalfInfShift  = 6'd7;    // exponent 30
  localparam logic [ShiftW-1:0] HalfSubShift  = 6'd36;   // exponent 1
  localparam logic [ShiftW-1:0] HalfBiasShift = 6'd37;
  localparam logic [ShiftW-1:0] ByteShift     = 6'd12;

  localparam logic [GainW-1:0] GainReset = 16'd4096;
  localparam logic [7:0]       AlphaOpaque = 8'hff;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic [ScaledW-1:0] scaled;
    logic [ShiftW-1:0]  shift;
  } lane_res_t;

endpackage
`default_nettype wire

[rtl/htx_lane.sv]
`default_nettype none
module htx_lane
  import htx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [ChanW-1:0] chan,
  input  wire logic             fmt,
  input  wire logic [GainW-1:0] gain,
  output lane_res_t             res
);

  logic             sign;
  logic [4:0]       expo;
  logic [9:0]       mant;
  logic [MantW-1:0] m;
  logic [ShiftW-1:0] sh;

  logic [ProdW-1:0]  prod_r, prod_nxt;
  logic [ShiftW-1:0] sh_r;
  logic              fmt_r;
  lane_res_t         res_r, res_nxt;

  assign sign = chan[15];
  assign expo = chan[14:10];
  assign mant = chan[9:0];

  // decode to integer mantissa and right shift
  always_comb begin
    m  = '0;
    sh = HalfInfShift;
    if (fmt == FormatByte) begin
      m  = MantW'(chan[ByteW-1:0]);
      sh = ByteShift;
    end else if (sign) begin
      m  = '0;
    end else if (expo == HalfExpMax) begin
      // nan reads as zero, infinity as the largest finite value
      m  = (mant != 10'd0) ? '0 : HalfInfMant;
      sh = HalfInfShift;
    end else if (expo == 5'd0) begin
      m  = MantW'(mant);
      sh = HalfSubShift;
    end else begin
      m  = HalfHidden | MantW'(mant);
      sh = HalfBiasShift - ShiftW'(expo);
    end
  end

  assign prod_nxt = ProdW'(m) * ProdW'(gain);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sh_r   <= sh;
    fmt_r  <= fmt;
  end

  // times 255 as a shift and subtract, byte mode skips it
  always_comb begin
    res_nxt.shift = sh_r;
    if (fmt_r == FormatByte) begin
      res_nxt.scaled = ScaledW'(prod_r);
    end else begin
      res_nxt.scaled = {prod_r, 8'd0} - ScaledW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

[rtl/htx_merge.sv]
`default_nettype none
module htx_merge
  import htx_pkg::*;
(
  input  wire logic      clk,
  input  wire lane_res_t lanes [NumLanes],
  output logic [31:0]    pixel
);

  logic [ScaledW-1:0] shifted [NumLanes];
  logic [ByteW-1:0]   bytes   [NumLanes];
  logic [31:0]        pixel_r, pixel_nxt;

  // floor by shift, then saturate to a byte
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      shifted[i] = lanes[i].scaled >> lanes[i].shift;
      bytes[i]   = (|shifted[i][ScaledW-1:ByteW]) ? 8'hff : shifted[i][ByteW-1:0];
    end
  end

  assign pixel_nxt = {AlphaOpaque, bytes[2], bytes[1], bytes[0]};

  always_ff @(posedge clk) begin
    pixel_r <= pixel_nxt;
  end

  assign pixel = pixel_r;

endmodule
`default_nettype wire

[rtl/half_texel_exposure_to_rgba8_top.sv]
`default_nettype none
// pipeline: decode and multiply, scale by 255, then shift, saturate and pack,
//   each step registered before the result is strobed on out_valid
// throughput: one texel per clock, three channel lanes in parallel; busy stays low
// the receiver cannot stall, every result shows for exactly one cycle
// reset (synchronous, active low) clears the pipeline valids and sets
//   source_format to half and exposure_gain to 1.0
module half_texel_exposure_to_rgba8_top
  import htx_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input transaction
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [ChanW-1:0] in_red_channel,
  input  wire logic [ChanW-1:0] in_green_channel,
  input  wire logic [ChanW-1:0] in_blue_channel,
  // result transaction
  output logic                  out_valid,
  output logic [31:0]           out_pixel_word,
  // configuration writes
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [GainW-1:0] cfg_data
);

  logic             source_format_r, source_format_nxt;
  logic [GainW-1:0] exposure_gain_r, exposure_gain_nxt;
  logic [2:0]       valid_r, valid_nxt;
  logic             accept;

  logic [ChanW-1:0] chans [NumLanes];
  lane_res_t        lane_res [NumLanes];

  // no back pressure anywhere, a new texel may enter every cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // configuration registers: the user must write them only while the pipeline is empty; the block does not enforce it
  always_comb begin
    source_format_nxt = source_format_r;
    exposure_gain_nxt = exposure_gain_r;
    if (cfg_we) begin
      case (cfg_index)
        CfgSourceFormat: source_format_nxt = cfg_data[0];
        CfgExposureGain: exposure_gain_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_format_r <= FormatHalf;
      exposure_gain_r <= GainReset;
    end else begin
      source_format_r <= source_format_nxt;
      exposure_gain_r <= exposure_gain_nxt;
    end
  end

  // valid travels alongside the three-stage datapath
  assign valid_nxt = {valid_r[1:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // lane order matches the packed byte order: red, green, blue
  assign chans[0] = in_red_channel;
  assign chans[1] = in_green_channel;
  assign chans[2] = in_blue_channel;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    htx_lane u_lane (
      .clk  (clk),
      .chan (chans[i]),
      .fmt  (source_format_r),
      .gain (exposure_gain_r),
      .res  (lane_res[i])
    );
  end

  // shift, saturate and pack into 0xffbbggrr
  htx_merge u_merge (
    .clk   (clk),
    .lanes (lane_res),
    .pixel (out_pixel_word)
  );

  assign out_valid = valid_r[2];

endmodule
`default_nettype wire

[rtl/htx_checker.sv]
`default_nettype none
module htx_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [31:0] out_pixel_word
);

  // the block never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted texel comes out as a result at the end of the pipeline
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##2 out_valid)
    else $error("result missing for accepted texel");

  // no result without a matching texel at the pipeline input
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result without texel");

  // alpha byte always opaque
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_word[31:24] == 8'hff))
    else $error("alpha not opaque");

endmodule

bind half_texel_exposure_to_rgba8_top htx_checker u_htx_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_pixel_word (out_pixel_word)
);
`default_nettype wire
